/* src/bvbq_pkg.sv */
// shared constants and types for the battery voltage burst qualifier
package bvbq_pkg;

  localparam int unsigned SAMPLES_PER_BURST = 16;
  localparam int unsigned ADC_FULL_SCALE    = 4095;
  localparam int unsigned BURSTS            = 3;

  localparam int ADC_W   = 12;
  localparam int VREF_W  = 13;
  localparam int SCALE_W = 12;
  localparam int MV_W    = 16;
  localparam int FAULT_W = 2;

  localparam int SUM_W  = $clog2(SAMPLES_PER_BURST * (2 ** ADC_W - 1) + 1);
  localparam int SCNT_W = (SAMPLES_PER_BURST > 1) ? $clog2(SAMPLES_PER_BURST) : 1;
  localparam int BIDX_W = $clog2(BURSTS);

  // divisor of the millivolt conversion and its half for round half up
  localparam int unsigned DEN      = SAMPLES_PER_BURST * ADC_FULL_SCALE * 256;
  localparam int unsigned HALF_DEN = DEN / 2;
  localparam int REM_W = $clog2(DEN);
  localparam int M1_W  = SUM_W + VREF_W;
  localparam int NUM_W = SUM_W + VREF_W + SCALE_W + 1;
  localparam int CNT_W = $clog2(NUM_W);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_VREF   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPREAD = 3'd4;

  localparam logic [FAULT_W-1:0] FAULT_OK     = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_RANGE  = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_SPREAD = 2'd2;

  typedef enum logic [3:0] {
    S_ACC  = 4'b0001,
    S_CONV = 4'b0010,
    S_SORT = 4'b0100,
    S_EVAL = 4'b1000
  } top_state_t;

  typedef enum logic [4:0] {
    C_IDLE = 5'b00001,
    C_MUL1 = 5'b00010,
    C_MUL2 = 5'b00100,
    C_RND  = 5'b01000,
    C_DIV  = 5'b10000
  } conv_state_t;

endpackage

/* src/battery_voltage_burst_qualifier.sv */
// top level of the battery voltage burst qualifier
// Usage: 12-bit ADC samples enter on the in_ channel (valid/stall); one
// qualified reading leaves on the out_ channel (valid/stall) after every
// three bursts of 16 samples. Registers are written over the cfg_ channel
// (valid/ready, always ready); the user must write them only while the
// block is idle, which the block itself does not enforce.
// Throughput: 16 samples are taken back to back, one per cycle. After the
// 16th sample the input stalls while the burst sum is converted to
// millivolts by the bit-serial converter: a start step, 13 multiply steps
// over the reference bits, 12 over the scale bits, one rounding add, 42
// restoring divide steps and a step to hand back the value. After the
// third burst the three values are sorted into registers, then the limits
// are checked as the result is loaded into the output register.
// The result sits in an output register; sampling for the next burst goes
// on while it waits. If the receiver still stalls when the next result is
// ready, the block holds in the evaluate step and stalls its input.
// Reset (synchronous, active low) restores the register defaults, empties
// the accumulator and restarts the three-burst cycle with no result pending.
module battery_voltage_burst_qualifier (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bvbq_pkg::ADC_W-1:0]      in_adc_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bvbq_pkg::MV_W-1:0]       out_battery_mv,
  output logic                            out_reading_valid,
  output logic [bvbq_pkg::FAULT_W-1:0]    out_fault_code,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bvbq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bvbq_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bvbq_pkg::*;

  top_state_t          state_r, state_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SCNT_W-1:0]   scnt_r, scnt_nxt;
  logic [BIDX_W-1:0]   bidx_r, bidx_nxt;
  logic                start_r, start_nxt;
  logic [MV_W-1:0]     burst_mv_r [BURSTS];

  logic [VREF_W-1:0]   vref_r;
  logic [SCALE_W-1:0]  scale_r;
  logic [MV_W-1:0]     min_r, max_r, spread_r;

  logic [MV_W-1:0]     lo_r, hi_r, med_r;
  logic [MV_W-1:0]     mn, mx, t, lo_c, hi_c, med_c;
  logic                ab, ac, bc;

  logic                out_valid_r;
  logic [MV_W-1:0]     out_mv_r;
  logic                out_rv_r;
  logic [FAULT_W-1:0]  out_fault_r;
  logic                out_free, out_load, in_xfer;

  logic                conv_done;
  logic [MV_W-1:0]     conv_mv;

  bvbq_conv u_conv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .sum      (sum_r),
    .vref_mv  (vref_r),
    .scale_q8 (scale_r),
    .done     (conv_done),
    .mv       (conv_mv)
  );

  assign in_stall = (state_r != S_ACC);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == S_EVAL) && out_free;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vref_r   <= VREF_W'(3300);
      scale_r  <= SCALE_W'(512);
      min_r    <= MV_W'(2000);
      max_r    <= MV_W'(5500);
      spread_r <= MV_W'(150);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_VREF:   vref_r   <= cfg_data[VREF_W-1:0];
        REG_SCALE:  scale_r  <= cfg_data[SCALE_W-1:0];
        REG_MIN:    min_r    <= cfg_data[MV_W-1:0];
        REG_MAX:    max_r    <= cfg_data[MV_W-1:0];
        REG_SPREAD: spread_r <= cfg_data[MV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sort of the three burst values, median = max(min(a,b), min(max(a,b),c))
  always_comb begin
    ab    = burst_mv_r[0] < burst_mv_r[1];
    ac    = burst_mv_r[0] < burst_mv_r[2];
    bc    = burst_mv_r[1] < burst_mv_r[2];
    lo_c  = (ab && ac) ? burst_mv_r[0] : (bc ? burst_mv_r[1] : burst_mv_r[2]);
    hi_c  = (!ab && !ac) ? burst_mv_r[0] : (!bc ? burst_mv_r[1] : burst_mv_r[2]);
    mn    = ab ? burst_mv_r[0] : burst_mv_r[1];
    mx    = ab ? burst_mv_r[1] : burst_mv_r[0];
    t     = (mx < burst_mv_r[2]) ? mx : burst_mv_r[2];
    med_c = (mn > t) ? mn : t;
  end

  always_comb begin
    state_nxt = state_r;
    sum_nxt   = sum_r;
    scnt_nxt  = scnt_r;
    bidx_nxt  = bidx_r;
    start_nxt = 1'b0;
    case (state_r)
      S_ACC: begin
        if (in_xfer) begin
          sum_nxt  = sum_r + SUM_W'(in_adc_sample);
          scnt_nxt = scnt_r + 1'b1;
          if (scnt_r == SCNT_W'(SAMPLES_PER_BURST - 1)) begin
            scnt_nxt  = '0;
            start_nxt = 1'b1;
            state_nxt = S_CONV;
          end
        end
      end
      S_CONV: begin
        if (conv_done) begin
          sum_nxt = '0;
          if (bidx_r == BIDX_W'(BURSTS - 1)) begin
            bidx_nxt  = '0;
            state_nxt = S_SORT;
          end else begin
            bidx_nxt  = bidx_r + 1'b1;
            state_nxt = S_ACC;
          end
        end
      end
      S_SORT: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (out_free) begin
          state_nxt = S_ACC;
        end
      end
      default: begin
        state_nxt = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      sum_r       <= '0;
      scnt_r      <= '0;
      bidx_r      <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      scnt_r  <= scnt_nxt;
      bidx_r  <= bidx_nxt;
      start_r <= start_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_CONV) && conv_done) begin
      burst_mv_r[bidx_r] <= conv_mv;
    end
    if (state_r == S_SORT) begin
      lo_r  <= lo_c;
      hi_r  <= hi_c;
      med_r <= med_c;
    end
    if (out_load) begin
      // range check wins over the spread check
      if ((med_r < min_r) || (med_r > max_r)) begin
        out_mv_r    <= '0;
        out_rv_r    <= 1'b0;
        out_fault_r <= FAULT_RANGE;
      end else if ((hi_r - lo_r) > spread_r) begin
        out_mv_r    <= '0;
        out_rv_r    <= 1'b0;
        out_fault_r <= FAULT_SPREAD;
      end else begin
        out_mv_r    <= med_r;
        out_rv_r    <= 1'b1;
        out_fault_r <= FAULT_OK;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_battery_mv    = out_mv_r;
  assign out_reading_valid = out_rv_r;
  assign out_fault_code    = out_fault_r;

`ifndef SYNTH
  a_result_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EVAL))
    else $error("result appeared without an evaluate step");

  a_valid_flag_matches_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_rv_r == (out_fault_r == FAULT_OK)))
    else $error("reading valid flag disagrees with fault code");

  a_invalid_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rv_r) |-> (out_mv_r == '0))
    else $error("invalid reading carries nonzero millivolts");

  a_done_only_converting: assert property (@(posedge clk) disable iff (!rst_n)
    conv_done |-> (state_r == S_CONV))
    else $error("converter finished outside the convert state");
`endif

endmodule

/* src/bvbq_conv.sv */
// bit-serial burst sum to millivolt converter: shift-add multiplies and restoring divide
module bvbq_conv (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [bvbq_pkg::SUM_W-1:0]   sum,
  input  logic [bvbq_pkg::VREF_W-1:0]  vref_mv,
  input  logic [bvbq_pkg::SCALE_W-1:0] scale_q8,
  output logic                         done,
  output logic [bvbq_pkg::MV_W-1:0]    mv
);
  import bvbq_pkg::*;

  conv_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [VREF_W-1:0]    vsh_r, vsh_nxt;
  logic [SCALE_W-1:0]   ssh_r, ssh_nxt;
  logic [M1_W-1:0]      m1_r, m1_nxt;
  logic [NUM_W-1:0]     num_r, num_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [MV_W-1:0]      q_r, q_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 done_r, done_nxt;
  logic [REM_W:0]       rem_sh;
  logic                 rem_ge;

  // one quotient bit per cycle
  assign rem_sh = {rem_r, num_r[NUM_W-1]};
  assign rem_ge = rem_sh >= (REM_W + 1)'(DEN);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    vsh_nxt   = vsh_r;
    ssh_nxt   = ssh_r;
    m1_nxt    = m1_r;
    num_nxt   = num_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    ovf_nxt   = ovf_r;
    done_nxt  = 1'b0;
    case (state_r)
      C_IDLE: begin
        if (start) begin
          vsh_nxt   = vref_mv;
          ssh_nxt   = scale_q8;
          m1_nxt    = '0;
          num_nxt   = '0;
          rem_nxt   = '0;
          q_nxt     = '0;
          ovf_nxt   = 1'b0;
          cnt_nxt   = CNT_W'(VREF_W - 1);
          state_nxt = C_MUL1;
        end
      end
      C_MUL1: begin
        m1_nxt  = {m1_r[M1_W-2:0], 1'b0} + (vsh_r[VREF_W-1] ? M1_W'(sum) : '0);
        vsh_nxt = {vsh_r[VREF_W-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          cnt_nxt   = CNT_W'(SCALE_W - 1);
          state_nxt = C_MUL2;
        end
      end
      C_MUL2: begin
        num_nxt = {num_r[NUM_W-2:0], 1'b0} + (ssh_r[SCALE_W-1] ? NUM_W'(m1_r) : '0);
        ssh_nxt = {ssh_r[SCALE_W-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = C_RND;
        end
      end
      C_RND: begin
        num_nxt   = num_r + NUM_W'(HALF_DEN);
        cnt_nxt   = CNT_W'(NUM_W - 1);
        state_nxt = C_DIV;
      end
      C_DIV: begin
        rem_nxt = rem_ge ? REM_W'(rem_sh - (REM_W + 1)'(DEN)) : rem_sh[REM_W-1:0];
        num_nxt = {num_r[NUM_W-2:0], 1'b0};
        q_nxt   = {q_r[MV_W-2:0], rem_ge};
        // any bit pushed out of the top saturates the result
        ovf_nxt = ovf_r | q_r[MV_W-1];
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          done_nxt  = 1'b1;
          state_nxt = C_IDLE;
        end
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    vsh_r <= vsh_nxt;
    ssh_r <= ssh_nxt;
    m1_r  <= m1_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    ovf_r <= ovf_nxt;
  end

  assign done = done_r;
  assign mv   = ovf_r ? {MV_W{1'b1}} : q_r;

endmodule
